// ===== design/point_transform_perspective_unit_defines.svh =====
// Assertion macros for the vertex transform unit
`ifndef POINT_TRANSFORM_PERSPECTIVE_UNIT_DEFINES_SVH
`define POINT_TRANSFORM_PERSPECTIVE_UNIT_DEFINES_SVH

// check while out of reset
`define PTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define PTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ptp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptp_pkg;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned INDEX_WIDTH     = 4;
  localparam logic        OP_LOAD         = 1'b0;
  localparam logic        OP_XFORM        = 1'b1;
endpackage
`default_nettype wire

// ===== design/point_transform_perspective_unit.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_stall_o | opcode, entry_index/value, point_x/y/z
// out     | output    | out_valid_o, out_stall_i | out_x/y/z, w_was_zero
//
// One item per cycle while the output is not stalled. A transform item passes
// through multiply, row sum, sign/magnitude, overflow check, one restoring division
// step per quotient bit, then saturation. A load writes the matrix at accept.
// Reset clears the matrix and all valid bits. A stalled output freezes the whole
// pipeline and raises in_stall_o in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "point_transform_perspective_unit_defines.svh"
module point_transform_perspective_unit #(
  parameter int unsigned COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = ptp_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  opcode_i,
  input  wire         [ptp_pkg::INDEX_WIDTH-1:0] entry_index_i,
  input  wire  signed [COORD_WIDTH-1:0]        entry_value_i,
  input  wire  signed [COORD_WIDTH-1:0]        point_x_i,
  input  wire  signed [COORD_WIDTH-1:0]        point_y_i,
  input  wire  signed [COORD_WIDTH-1:0]        point_z_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [COORD_WIDTH-1:0]        out_x_o,
  output logic signed [COORD_WIDTH-1:0]        out_y_o,
  output logic signed [COORD_WIDTH-1:0]        out_z_o,
  output logic                                 w_was_zero_o
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned DW = SW + W + 1;

  logic adv, in_acc;
  logic signed [W-1:0] mat_q [ptp_pkg::ENTRIES];
  logic signed [W-1:0] pt [3];

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptp_pkg::ENTRIES; i++) mat_q[i] <= '0;
    end else if (in_acc && opcode_i == ptp_pkg::OP_LOAD) begin
      mat_q[entry_index_i] <= entry_value_i;
    end
  end

  // stage 1: products
  logic                v1_q;
  logic signed [PW-1:0] p1_q [4][3];
  logic signed [W-1:0]  c1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc && opcode_i == ptp_pkg::OP_XFORM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_q[r][c] <= PW'(mat_q[r + 4 * c]) * PW'(pt[c]);
        end
        c1_q[r] <= mat_q[r + 12];
      end
    end
  end

  // stage 2: row sums
  logic                v2_q;
  logic signed [SW-1:0] s2_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        s2_q[r] <= SW'(p1_q[r][0]) + SW'(p1_q[r][1]) + SW'(p1_q[r][2])
                 + (SW'(c1_q[r]) <<< F);
      end
    end
  end

  // stage 3: signs and magnitudes
  logic          v3_q, wz3_q;
  logic [DW-1:0] n3_q [3];
  logic [DW-1:0] d3_q;
  logic          neg3_q [3];
  logic          wz;
  logic [SW-1:0] wmag;

  assign wz   = s2_q[3] == '0;
  assign wmag = s2_q[3][SW-1] ? SW'(-s2_q[3]) : SW'(s2_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wz3_q <= wz;
      d3_q  <= wz ? (DW'(1) << (2 * F)) : DW'(wmag);
      for (int r = 0; r < 3; r++) begin
        neg3_q[r] <= s2_q[r][SW-1] ^ (s2_q[3][SW-1] && !wz);
        n3_q[r]   <= (s2_q[r][SW-1] ? DW'(SW'(-s2_q[r])) : DW'(SW'(s2_q[r]))) << F;
      end
    end
  end

  // division: overflow check, then one quotient bit per stage
  logic          dv_q   [W+1];
  logic          dwz_q  [W+1];
  logic [DW-1:0] dd_q   [W+1];
  logic [DW-1:0] rem_q  [W+1][3];
  logic [W-1:0]  quo_q  [W+1][3];
  logic          ovf_q  [W+1][3];
  logic          dneg_q [W+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dwz_q[0] <= wz3_q;
      dd_q[0]  <= d3_q;
      for (int r = 0; r < 3; r++) begin
        rem_q[0][r]  <= n3_q[r];
        quo_q[0][r]  <= '0;
        ovf_q[0][r]  <= n3_q[r] >= (d3_q << W);
        dneg_q[0][r] <= neg3_q[r];
      end
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    logic [DW-1:0] dsh;
    assign dsh = dd_q[j-1] << (W - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (adv) begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dwz_q[j] <= dwz_q[j-1];
        dd_q[j]  <= dd_q[j-1];
        for (int r = 0; r < 3; r++) begin
          ovf_q[j][r]  <= ovf_q[j-1][r];
          dneg_q[j][r] <= dneg_q[j-1][r];
          if (!ovf_q[j-1][r] && rem_q[j-1][r] >= dsh) begin
            rem_q[j][r] <= rem_q[j-1][r] - dsh;
            quo_q[j][r] <= quo_q[j-1][r] | (W'(1) << (W - j));
          end else begin
            rem_q[j][r] <= rem_q[j-1][r];
            quo_q[j][r] <= quo_q[j-1][r];
          end
        end
      end
    end
  end

  // output: saturate and apply sign
  logic         ov_q;
  logic [W-1:0] res [3];
  logic [W-1:0] lim [3];
  logic [W-1:0] mag [3];
  logic [W-1:0] ox_q, oy_q, oz_q;
  logic         owz_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lim[r] = dneg_q[W][r] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      mag[r] = (ovf_q[W][r] || quo_q[W][r] > lim[r]) ? lim[r] : quo_q[W][r];
      res[r] = dneg_q[W][r] ? W'(-mag[r]) : mag[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q  <= res[0];
      oy_q  <= res[1];
      oz_q  <= res[2];
      owz_q <= dwz_q[W];
    end
  end

  assign out_valid_o  = ov_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_z_o      = oz_q;
  assign w_was_zero_o = owz_q;

  `PTP_ASSERT(a_load_no_result, in_acc && opcode_i == ptp_pkg::OP_LOAD |=> !v1_q, "load made item")
  `PTP_ASSERT(a_load_write, in_acc && opcode_i == ptp_pkg::OP_LOAD |=> mat_q[$past(entry_index_i)] == $past(entry_value_i), "matrix write lost")
  `PTP_ASSERT(a_stall_hold, !adv |=> out_valid_o == $past(out_valid_o) && dv_q[W] == $past(dv_q[W]), "stall moved pipeline")
  `PTP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !v1_q, "valid in reset")
endmodule
`default_nettype wire

// ===== test/tb_point_transform_perspective_unit.sv =====
`timescale 1ns / 1ps
module tb_point_transform_perspective_unit;

  localparam int CW            = 32;
  localparam int FB            = 16;
  localparam int LATENCY       = CW + 5;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 wz;
  } vertex_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [ptp_pkg::INDEX_WIDTH-1:0] entry_index_i;
  logic signed [CW-1:0] entry_value_i;
  logic signed [CW-1:0] point_x_i;
  logic signed [CW-1:0] point_y_i;
  logic signed [CW-1:0] point_z_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [CW-1:0] out_x_o;
  logic signed [CW-1:0] out_y_o;
  logic signed [CW-1:0] out_z_o;
  logic                 w_was_zero_o;

  logic signed [CW-1:0] matrix_copy [ptp_pkg::ENTRIES];
  vertex_t              pending_vertices [$];
  int                   mismatches = 0;
  int                   cycles = 0;
  int                   idle_pct;
  int                   stall_pct;
  logic                 hold_start;
  int                   hold_left = 0;

  point_transform_perspective_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .entry_index_i(entry_index_i), .entry_value_i(entry_value_i),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .w_was_zero_o(w_was_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [95:0] row_sum(int r, logic signed [CW-1:0] px,
                                                 logic signed [CW-1:0] py,
                                                 logic signed [CW-1:0] pz);
    logic signed [95:0] a0, a1, a2, a3, bx, by, bz;
    a0 = matrix_copy[r];
    a1 = matrix_copy[r+4];
    a2 = matrix_copy[r+8];
    a3 = matrix_copy[r+12];
    bx = px;
    by = py;
    bz = pz;
    return a0 * bx + a1 * by + a2 * bz + (a3 <<< FB);
  endfunction

  function automatic logic signed [CW-1:0] divide_clamped(logic signed [95:0] num,
                                                          logic signed [95:0] den);
    logic [127:0] nm, dm, q, lim;
    logic         neg;
    neg = num[95] ^ den[95];
    nm  = {32'b0, (num[95] ? -num : num)};
    dm  = {32'b0, (den[95] ? -den : den)};
    q   = (nm << FB) / dm;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[CW-1:0] : q[CW-1:0];
  endfunction

  function automatic vertex_t project_vertex(logic signed [CW-1:0] px,
                                             logic signed [CW-1:0] py,
                                             logic signed [CW-1:0] pz);
    vertex_t            v;
    logic signed [95:0] w;
    w    = row_sum(3, px, py, pz);
    v.wz = (w == 0);
    if (v.wz) w = 96'sd1 <<< (2 * FB);
    v.x  = divide_clamped(row_sum(0, px, py, pz), w);
    v.y  = divide_clamped(row_sum(1, px, py, pz), w);
    v.z  = divide_clamped(row_sum(2, px, py, pz), w);
    return v;
  endfunction

  task automatic send_item(logic op, logic [ptp_pkg::INDEX_WIDTH-1:0] idx,
                           logic signed [CW-1:0] val,
                           logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                           logic signed [CW-1:0] pz);
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    point_x_i     <= px;
    point_y_i     <= py;
    point_z_i     <= pz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == ptp_pkg::OP_LOAD) matrix_copy[idx] = val;
    else pending_vertices.push_back(project_vertex(px, py, pz));
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic load_entry(int idx, logic signed [CW-1:0] val);
    send_item(ptp_pkg::OP_LOAD, ptp_pkg::INDEX_WIDTH'(idx), val, $urandom, $urandom, $urandom);
  endtask

  task automatic xform(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                       logic signed [CW-1:0] pz);
    send_item(ptp_pkg::OP_XFORM, ptp_pkg::INDEX_WIDTH'($urandom), $urandom, px, py, pz);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'sh8000_0000 + $urandom_range(0, 3);
      2:       return 32'sh7fff_ffff - $urandom_range(0, 3);
      3:       return 0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic test_reset_matrix();
    xform(32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    drain();
  endtask

  task automatic test_directed();
    for (int i = 0; i < ptp_pkg::ENTRIES; i++) load_entry(i, (i % 5 == 0) ? 32'sh0001_0000 : 0);
    xform(32'sh0002_8000, -32'sh0001_0000, 32'sh7fff_ffff);
    xform(32'sh8000_0000, 0, 32'sh0000_0001);
    load_entry(15, 0);
    xform(32'sh0003_0000, 32'sh0001_0000, -32'sh0000_0001);
    load_entry(3, 32'sh0000_0001);
    load_entry(0, 32'sh7fff_ffff);
    load_entry(4, 32'sh8000_0000);
    xform(32'sh7fff_ffff, 32'sh0001_0000, 32'sh0004_0000);
    xform(-32'sh0000_0001, 32'sh7fff_ffff, 0);
    load_entry(15, -32'sh0002_0000);
    xform(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    drain();
  endtask

  task automatic random_batches(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < ptp_pkg::ENTRIES; i++) begin
        if ($urandom_range(3) == 0 && (i % 4) == 3) load_entry(i, 0);
        else if ($urandom_range(5) != 0) load_entry(i, rand_coord());
      end
      sent += ptp_pkg::ENTRIES;
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(19) == 0) load_entry($urandom, rand_coord());
        else xform(rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_random_phases();
    idle_pct = 0;  stall_pct = 0;  random_batches(430);
    idle_pct = 74; stall_pct = 0;  random_batches(430);
    idle_pct = 0;  stall_pct = 74; random_batches(430);
    idle_pct = 15; stall_pct = 15; random_batches(430);
  endtask

  task automatic test_backpressure();
    idle_pct   = 0;
    stall_pct  = 0;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (80) xform(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_start) hold_left = HOLD_CYCLES;
    else if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h wz=%b",
                                       out_x_o, out_y_o, out_z_o, w_was_zero_o);
      end else begin
        want = pending_vertices.pop_front();
        if (out_x_o !== want.x || out_y_o !== want.y || out_z_o !== want.z ||
            w_was_zero_o !== want.wz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h wz=%b got x=%h y=%h z=%h wz=%b",
                     want.x, want.y, want.z, want.wz,
                     out_x_o, out_y_o, out_z_o, w_was_zero_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = ptp_pkg::OP_LOAD;
    entry_index_i = '0;
    entry_value_i = '0;
    point_x_i     = '0;
    point_y_i     = '0;
    point_z_i     = '0;
    hold_start    = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    for (int i = 0; i < ptp_pkg::ENTRIES; i++) matrix_copy[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_directed();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/ptp_pkg.sv
design/point_transform_perspective_unit.sv
test/tb_point_transform_perspective_unit.sv
